// ----- design/mm4_pkg.sv -----
package mm4_pkg;

  // Element and result value width, and the saturation range of a result.
  localparam int ELEM_BITS = 32;
  localparam int VALUE_BITS = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int POS_BITS = 4;
  localparam int DEPTH = 16;
  localparam int PROD_W = 2 * ELEM_BITS;
  localparam int ACC_W = PROD_W + 2;
  localparam int STEP_BITS = 3;

  // One beat on the element channel.
  typedef struct packed {
    logic signed [ELEM_BITS-1:0] element_value;
    logic right_operand;
    logic [POS_BITS-1:0] element_position;
    logic start_compute;
  } elem_beat_t;

  // One beat on the product channel.
  typedef struct packed {
    logic signed [ELEM_BITS-1:0] product_value;
    logic [POS_BITS-1:0] product_position;
    logic saturated;
    logic last_result;
  } prod_beat_t;

  // How the step counter moves after a step.
  typedef enum logic [1:0] {
    COND_NEXT,
    COND_START,
    COND_OUT
  } seq_cond_t;

  // One control word of the program.
  typedef struct packed {
    logic take;
    logic rd_en;
    logic [1:0] k;
    logic mul_en;
    logic acc_load;
    logic acc_en;
    logic out_step;
    seq_cond_t cond;
    logic [STEP_BITS-1:0] target;
  } ucode_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic rd_en;
    logic [1:0] k;
    logic mul_en;
    logic acc_load;
    logic acc_en;
    logic out_load;
    logic [POS_BITS-1:0] elem;
    logic last;
  } mm4_ctrl_t;

  // Program addresses.
  localparam logic [STEP_BITS-1:0] STEP_IDLE = 3'd0;
  localparam logic [STEP_BITS-1:0] STEP_RD0 = 3'd1;
  localparam logic [STEP_BITS-1:0] STEP_RD1 = 3'd2;
  localparam logic [STEP_BITS-1:0] STEP_RD2 = 3'd3;
  localparam logic [STEP_BITS-1:0] STEP_RD3 = 3'd4;
  localparam logic [STEP_BITS-1:0] STEP_MUL3 = 3'd5;
  localparam logic [STEP_BITS-1:0] STEP_ACC3 = 3'd6;
  localparam logic [STEP_BITS-1:0] STEP_EMIT = 3'd7;

  // The program for one product element: four reads, four multiplies and
  // four accumulations overlapped, then the result is handed to the output.
  function automatic ucode_t ucode_rom(input logic [STEP_BITS-1:0] step);
    ucode_t w;
    w = '0;
    w.cond = COND_NEXT;
    unique case (step)
      STEP_IDLE: begin
        w.take = 1'b1;
        w.cond = COND_START;
        w.target = STEP_RD0;
      end
      STEP_RD0: begin
        w.rd_en = 1'b1;
        w.k = 2'd0;
      end
      STEP_RD1: begin
        w.rd_en = 1'b1;
        w.k = 2'd1;
        w.mul_en = 1'b1;
      end
      STEP_RD2: begin
        w.rd_en = 1'b1;
        w.k = 2'd2;
        w.mul_en = 1'b1;
        w.acc_load = 1'b1;
      end
      STEP_RD3: begin
        w.rd_en = 1'b1;
        w.k = 2'd3;
        w.mul_en = 1'b1;
        w.acc_en = 1'b1;
      end
      STEP_MUL3: begin
        w.mul_en = 1'b1;
        w.acc_en = 1'b1;
      end
      STEP_ACC3: begin
        w.acc_en = 1'b1;
      end
      STEP_EMIT: begin
        w.out_step = 1'b1;
        w.cond = COND_OUT;
        w.target = STEP_RD0;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- design/mm4_ram.sv -----
module mm4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/mm4_sequencer.sv -----
module mm4_sequencer
  import mm4_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      elem_valid,
  input  logic      start_compute,
  input  logic      out_free,
  output logic      elem_ready,
  output mm4_ctrl_t ctrl
);

  logic [STEP_BITS-1:0] step;
  logic [STEP_BITS-1:0] step_next;
  logic [POS_BITS-1:0]  elem;
  logic [POS_BITS-1:0]  elem_next;
  ucode_t               cw;
  logic                 last;

  assign cw = ucode_rom(step);
  assign last = (elem == POS_BITS'(DEPTH - 1));
  assign elem_ready = cw.take;

  // Step counter and element counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
      elem <= '0;
    end else begin
      step <= step_next;
      elem <= elem_next;
    end
  end

  // Conditional jumps of the program.
  always_comb begin
    step_next = step;
    elem_next = elem;
    unique case (cw.cond)
      COND_NEXT: begin
        step_next = step + STEP_BITS'(1);
      end
      COND_START: begin
        if (elem_valid && start_compute) begin
          step_next = cw.target;
        end
      end
      COND_OUT: begin
        if (out_free) begin
          elem_next = elem + POS_BITS'(1);
          step_next = last ? STEP_IDLE : cw.target;
        end
      end
      default: begin
        step_next = STEP_IDLE;
      end
    endcase
  end

  // Control word fields towards the datapath.
  always_comb begin
    ctrl.rd_en = cw.rd_en;
    ctrl.k = cw.k;
    ctrl.mul_en = cw.mul_en;
    ctrl.acc_load = cw.acc_load;
    ctrl.acc_en = cw.acc_en;
    ctrl.out_load = cw.out_step && out_free;
    ctrl.elem = elem;
    ctrl.last = last;
  end

endmodule

// ----- design/mm4_datapath.sv -----
module mm4_datapath
  import mm4_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  elem_beat_t wr_beat,
  input  mm4_ctrl_t  ctrl,
  output logic       out_free,
  output logic       prod_valid,
  input  logic       prod_ready,
  output prod_beat_t prod_data
);

  localparam logic signed [ACC_W-1:0] MAX_V = (ACC_W'(1) <<< (VALUE_BITS - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] MIN_V = -(ACC_W'(1) <<< (VALUE_BITS - 1));

  logic [ELEM_BITS-1:0]      left_rd;
  logic [ELEM_BITS-1:0]      right_rd;
  logic signed [ELEM_BITS-1:0] left_s;
  logic signed [ELEM_BITS-1:0] right_s;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   shifted;
  logic signed [ACC_W-1:0]   clipped;
  logic [ACC_W-VALUE_BITS:0] upper;
  logic                      fits;
  logic [POS_BITS-1:0]       left_addr;
  logic [POS_BITS-1:0]       right_addr;

  // Left is read along a row, right along a column.
  assign left_addr = {ctrl.k, ctrl.elem[1:0]};
  assign right_addr = {ctrl.elem[3:2], ctrl.k};

  mm4_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_left (
    .clk   (clk),
    .we    (wr_en && !wr_beat.right_operand),
    .waddr (wr_beat.element_position),
    .wdata (wr_beat.element_value),
    .re    (ctrl.rd_en),
    .raddr (left_addr),
    .rdata (left_rd)
  );

  mm4_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_right (
    .clk   (clk),
    .we    (wr_en && wr_beat.right_operand),
    .waddr (wr_beat.element_position),
    .wdata (wr_beat.element_value),
    .re    (ctrl.rd_en),
    .raddr (right_addr),
    .rdata (right_rd)
  );

  assign left_s = $signed(left_rd);
  assign right_s = $signed(right_rd);

  // Product register and accumulator.
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= left_s * right_s;
    end
    if (ctrl.acc_load) begin
      acc <= ACC_W'(prod);
    end else if (ctrl.acc_en) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // Floor shift and saturation to the result range.
  assign shifted = acc >>> FRAC_BITS;
  assign upper = shifted[ACC_W-1:VALUE_BITS-1];
  assign fits = (&upper) || !(|upper);
  assign clipped = fits ? shifted : (shifted[ACC_W-1] ? MIN_V : MAX_V);

  assign out_free = !prod_valid || prod_ready;

  // Output register: holds a result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      prod_valid <= 1'b1;
    end else if (prod_ready) begin
      prod_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      prod_data.product_value <= clipped[ELEM_BITS-1:0];
      prod_data.product_position <= ctrl.elem;
      prod_data.saturated <= !fits;
      prod_data.last_result <= ctrl.last;
    end
  end

endmodule

// ----- design/matrix_4x4_multiply_unit.sv -----
// 4x4 matrix multiply of signed Q16.16 values, both operands column-major.
// Element channel (elem_valid/elem_ready/elem_data): each beat writes one
// element into the left or right store; a beat with start_compute set then
// starts a run that gives all 16 product elements, column by column.
// Product channel (prod_valid/prod_ready/prod_data): one beat per element,
// last_result marks the sixteenth. Sums are exact, floor-shifted by
// FRAC_BITS and saturated, with the saturated flag set on clipping.
// A write-only beat leaves the sequencer idle and ready for the next beat. A
// compute run steps through the 16 elements on one shared multiplier and
// accumulator, each element taking the microprogram steps RD0 to RD3, MUL3,
// ACC3 and EMIT; elem_ready is high again once the last result is loaded.
// elem_ready is low during a run. When the receiver stalls, the program
// waits on the emit step with the next result held back until the output
// register is free. Reset clears the sequencer and the output valid; the
// stores are not cleared, so an element must be written before it is used.
module matrix_4x4_multiply_unit
  import mm4_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       elem_valid,
  output logic       elem_ready,
  input  elem_beat_t elem_data,
  output logic       prod_valid,
  input  logic       prod_ready,
  output prod_beat_t prod_data
);

  mm4_ctrl_t ctrl;
  logic      out_free;

  mm4_sequencer u_seq (
    .clk           (clk),
    .rst           (rst),
    .elem_valid    (elem_valid),
    .start_compute (elem_data.start_compute),
    .out_free      (out_free),
    .elem_ready    (elem_ready),
    .ctrl          (ctrl)
  );

  mm4_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (elem_valid && elem_ready),
    .wr_beat    (elem_data),
    .ctrl       (ctrl),
    .out_free   (out_free),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod_data  (prod_data)
  );

endmodule

// ----- test/testbench.sv -----
module testbench;
  import mm4_pkg::*;

  localparam int CLK_HALF = 6;
  localparam int RESET_CYCLES = 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 20;
  localparam logic signed [ACC_W-1:0] SUM_MAX = (ACC_W'(1) <<< (VALUE_BITS - 1)) - 1;
  localparam logic signed [ACC_W-1:0] SUM_MIN = -(ACC_W'(1) <<< (VALUE_BITS - 1));
  localparam logic [ELEM_BITS-1:0] MOST_NEG = 32'h8000_0000;
  localparam logic [ELEM_BITS-1:0] MOST_POS = 32'h7FFF_FFFF;
  localparam logic [ELEM_BITS-1:0] ONE_LSB = 32'h0000_0001;
  localparam logic [ELEM_BITS-1:0] MINUS_LSB = 32'hFFFF_FFFF;
  localparam logic [ELEM_BITS-1:0] Q_ONE = 32'h0001_0000;
  localparam logic [ELEM_BITS-1:0] ZERO_VAL = 32'h0000_0000;
  localparam bit LEFT_M = 1'b0;
  localparam bit RIGHT_M = 1'b1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic elem_valid = 1'b0;
  logic elem_ready;
  elem_beat_t elem_data = '0;
  logic prod_valid;
  logic prod_ready = 1'b0;
  prod_beat_t prod_data;

  // Operand copies held by the predictor, and the queues on either side.
  logic signed [ELEM_BITS-1:0] left_elems [DEPTH];
  logic signed [ELEM_BITS-1:0] right_elems [DEPTH];
  elem_beat_t element_queue [$];
  prod_beat_t expected_products [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  matrix_4x4_multiply_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .elem_valid (elem_valid),
    .elem_ready (elem_ready),
    .elem_data  (elem_data),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod_data  (prod_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // One product element: exact sum of four products, floor shift, saturation.
  function automatic prod_beat_t product_element(input int col, input int row);
    logic signed [ACC_W-1:0] sum;
    logic signed [ACC_W-1:0] shifted;
    prod_beat_t res;
    int k;
    sum = '0;
    for (k = 0; k < 4; k++) begin
      sum = sum + left_elems[k * 4 + row] * right_elems[col * 4 + k];
    end
    shifted = sum >>> FRAC_BITS_DEF;
    res = '0;
    res.product_position = POS_BITS'(col * 4 + row);
    if (shifted > SUM_MAX) begin
      res.product_value = SUM_MAX[ELEM_BITS-1:0];
      res.saturated = 1'b1;
    end else if (shifted < SUM_MIN) begin
      res.product_value = SUM_MIN[ELEM_BITS-1:0];
      res.saturated = 1'b1;
    end else begin
      res.product_value = shifted[ELEM_BITS-1:0];
      res.saturated = 1'b0;
    end
    return res;
  endfunction

  // An accepted beat updates the stores and, on compute, queues all 16 products.
  task automatic store_and_multiply(input elem_beat_t beat);
    prod_beat_t res;
    int col;
    int row;
    if (beat.right_operand) begin
      right_elems[beat.element_position] = beat.element_value;
    end else begin
      left_elems[beat.element_position] = beat.element_value;
    end
    if (beat.start_compute) begin
      for (col = 0; col < 4; col++) begin
        for (row = 0; row < 4; row++) begin
          res = product_element(col, row);
          res.last_result = (col == 3 && row == 3);
          expected_products.push_back(res);
        end
      end
    end
  endtask

  task automatic push_element(input logic [ELEM_BITS-1:0] value, input bit right,
                              input int pos, input bit compute);
    elem_beat_t beat;
    beat.element_value = value;
    beat.right_operand = right;
    beat.element_position = POS_BITS'(pos);
    beat.start_compute = compute;
    element_queue.push_back(beat);
  endtask

  // Edge cases, small Q16.16 values within plus or minus four, and full-range words.
  function automatic logic [ELEM_BITS-1:0] random_value();
    int pick;
    pick = $urandom_range(7);
    case (pick)
      0: begin
        case ($urandom_range(4))
          0: return MOST_NEG;
          1: return MOST_POS;
          2: return ZERO_VAL;
          3: return MINUS_LSB;
          default: return Q_ONE;
        endcase
      end
      1, 2, 3: return ELEM_BITS'($urandom_range(32'h0008_0000)) - 32'h0004_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_random(input int count);
    int i;
    for (i = 0; i < count; i++) begin
      push_element(random_value(), 1'($urandom_range(1)), $urandom_range(DEPTH - 1),
                   $urandom_range(7) == 0);
    end
  endtask

  // Wait until every queued beat has gone in and every product has come out.
  task automatic wait_drained();
    @(negedge clk);
    while (element_queue.size() != 0 || elem_valid || expected_products.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic report_field(input string field, input logic [ELEM_BITS-1:0] exp_val,
                              input logic [ELEM_BITS-1:0] act_val);
    mismatch_count++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_val, act_val);
  endtask

  // Element channel driver: a free channel gets the next queued beat, bar random gaps.
  always @(posedge clk) begin
    if (rst) begin
      elem_valid <= 1'b0;
    end else begin
      if (elem_valid && elem_ready) begin
        store_and_multiply(elem_data);
      end
      if (!elem_valid || elem_ready) begin
        if (element_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          elem_data <= element_queue.pop_front();
          elem_valid <= 1'b1;
        end else begin
          elem_valid <= 1'b0;
        end
      end
    end
  end

  // Product channel monitor: each beat is checked against the oldest expectation.
  always @(posedge clk) begin
    prod_beat_t exp_beat;
    if (rst) begin
      prod_ready <= 1'b0;
    end else begin
      if (prod_valid && prod_ready) begin
        if (expected_products.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected product beat, actual %h", $time, prod_data);
        end else begin
          exp_beat = expected_products.pop_front();
          if (prod_data.product_value !== exp_beat.product_value) begin
            report_field("product_value", exp_beat.product_value, prod_data.product_value);
          end
          if (prod_data.product_position !== exp_beat.product_position) begin
            report_field("product_position", ELEM_BITS'(exp_beat.product_position),
                         ELEM_BITS'(prod_data.product_position));
          end
          if (prod_data.saturated !== exp_beat.saturated) begin
            report_field("saturated", ELEM_BITS'(exp_beat.saturated),
                         ELEM_BITS'(prod_data.saturated));
          end
          if (prod_data.last_result !== exp_beat.last_result) begin
            report_field("last_result", ELEM_BITS'(exp_beat.last_result),
                         ELEM_BITS'(prod_data.last_result));
          end
        end
      end
      prod_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** matrix_4x4_multiply_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    int i;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Both stores are filled before anything is read; the final write computes.
    for (i = 0; i < 2 * DEPTH; i++) begin
      push_element(random_value(), 1'(i % 2), i / 2, i == 2 * DEPTH - 1);
    end

    // Row 0 of the left and column 0 of the right at the most negative value:
    // the first product saturates high.
    for (i = 0; i < 4; i++) push_element(MOST_NEG, LEFT_M, i * 4, 1'b0);
    for (i = 0; i < 4; i++) push_element(MOST_NEG, RIGHT_M, i, i == 3);
    // Column 0 of the right at the most positive value: it saturates low.
    for (i = 0; i < 4; i++) push_element(MOST_POS, RIGHT_M, i, i == 3);
    // A single product of one LSB by minus one LSB floors to minus one LSB.
    push_element(ONE_LSB, LEFT_M, 0, 1'b0);
    push_element(ZERO_VAL, LEFT_M, 4, 1'b0);
    push_element(ZERO_VAL, LEFT_M, 8, 1'b0);
    push_element(ZERO_VAL, LEFT_M, 12, 1'b0);
    push_element(MINUS_LSB, RIGHT_M, 0, 1'b1);
    // The top position, written and used by the same beat.
    push_element(Q_ONE, RIGHT_M, DEPTH - 1, 1'b1);

    push_random(70);
    wait_drained();

    // Sender gaps only.
    send_idle_pct = 46;
    recv_stall_pct = 0;
    push_random(110);
    wait_drained();

    // Receiver stalls only.
    send_idle_pct = 0;
    recv_stall_pct = 46;
    push_random(110);
    wait_drained();

    // Gaps and stalls together.
    send_idle_pct = 34;
    recv_stall_pct = 34;
    push_random(110);
    wait_drained();

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && expected_products.size() == 0) begin
      $display("** matrix_4x4_multiply_unit: PASSED **");
    end else begin
      $display("** matrix_4x4_multiply_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/mm4_pkg.sv
design/mm4_ram.sv
design/mm4_sequencer.sv
design/mm4_datapath.sv
design/matrix_4x4_multiply_unit.sv
test/testbench.sv
